[design/blu_pkg.sv]
package blu_pkg;

    localparam int MAX_SRC_WIDTH_DEF  = 2048;
    localparam int MAX_SRC_HEIGHT_DEF = 4096;

    localparam int PIX_W      = 8;
    localparam int DST_COL_W  = 12;
    localparam int DST_ROW_W  = 13;
    localparam int CFG_WID_W  = 12;
    localparam int CFG_HGT_W  = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int TDATA_W    = 40;   // 8 + 12 + 13 = 33 bits, padded to 5 bytes
    localparam int WGT_W      = 5;
    localparam int CFG_WID_RST = 2048;
    localparam int CFG_HGT_RST = 4096;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_WIDTH  = 1'b0,
        CFG_SRC_HEIGHT = 1'b1
    } t_cfg_reg;

    // destination row of a result relative to the source pixel
    typedef enum logic [1:0] {
        ROW_TOP,    // first destination row, horizontal blend only
        ROW_UP,     // row 2r-1, nearer the upper source row
        ROW_DN,     // row 2r, nearer the current source row
        ROW_BOT     // last destination row, horizontal blend only
    } t_row_kind;

    // destination column of a result relative to the source pixel
    typedef enum logic [1:0] {
        COL_FIRST,  // column 0
        COL_ODD,    // column 2c-1
        COL_EVEN,   // column 2c
        COL_LAST    // column 2w-1
    } t_col_kind;

    typedef struct packed {
        logic [PIX_W-1:0] ul;
        logic [PIX_W-1:0] up;
        logic [PIX_W-1:0] lf;
        logic [PIX_W-1:0] p;
        logic             first_col;
        logic             last_col;
        logic             first_row;
        logic             last_row;
    } t_item;

    typedef struct packed {
        logic [WGT_W-1:0] ul;
        logic [WGT_W-1:0] up;
        logic [WGT_W-1:0] lf;
        logic [WGT_W-1:0] p;
    } t_weights;

    // All blends in sixteenths: a 3:1 pair becomes 12:4 under the same shift by 4.
    function automatic t_weights blend_weights(t_row_kind rk, t_col_kind ck);
        t_weights wt;
        wt = '{ul: 5'd0, up: 5'd0, lf: 5'd0, p: 5'd16};
        case (rk)
            ROW_UP: begin
                case (ck)
                    COL_ODD:  wt = '{ul: 5'd9, up: 5'd3, lf: 5'd3, p: 5'd1};
                    COL_EVEN: wt = '{ul: 5'd3, up: 5'd9, lf: 5'd1, p: 5'd3};
                    default:  wt = '{ul: 5'd0, up: 5'd12, lf: 5'd0, p: 5'd4};
                endcase
            end
            ROW_DN: begin
                case (ck)
                    COL_ODD:  wt = '{ul: 5'd3, up: 5'd1, lf: 5'd9, p: 5'd3};
                    COL_EVEN: wt = '{ul: 5'd1, up: 5'd3, lf: 5'd3, p: 5'd9};
                    default:  wt = '{ul: 5'd0, up: 5'd4, lf: 5'd0, p: 5'd12};
                endcase
            end
            default: begin
                case (ck)
                    COL_ODD:  wt = '{ul: 5'd0, up: 5'd0, lf: 5'd12, p: 5'd4};
                    COL_EVEN: wt = '{ul: 5'd0, up: 5'd0, lf: 5'd4, p: 5'd12};
                    default:  wt = '{ul: 5'd0, up: 5'd0, lf: 5'd0, p: 5'd16};
                endcase
            end
        endcase
        return wt;
    endfunction

endpackage

[design/blu_ram.sv]
module blu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read-first: a read and a write of one address in a cycle return the old word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/blu_emit.sv]
module blu_emit #(
    parameter int COL_W = 11,
    parameter int ROW_W = 12
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_load,
    input  blu_pkg::t_item               i_item,
    input  logic [COL_W-1:0]             i_col,
    input  logic [COL_W-1:0]             i_wm1,
    input  logic [ROW_W-1:0]             i_row,
    input  logic [ROW_W-1:0]             i_hm1,
    output logic                         o_ready,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [blu_pkg::TDATA_W-1:0]  o_data,
    output logic                         o_last,
    output logic                         o_user
);
    import blu_pkg::*;

    localparam int CXW = (COL_W + 1 > DST_COL_W) ? COL_W + 1 : DST_COL_W;
    localparam int RXW = (ROW_W + 1 > DST_ROW_W) ? ROW_W + 1 : DST_ROW_W;

    logic             r_s2_valid;
    t_row_kind        r_rk;
    t_col_kind        r_ck;
    t_item            r_item;
    logic [COL_W-1:0] r_col;
    logic [COL_W-1:0] r_wm1;
    logic [ROW_W-1:0] r_row;
    logic [ROW_W-1:0] r_hm1;

    logic               r_m_valid;
    logic [TDATA_W-1:0] r_m_data;
    logic               r_m_last;
    logic               r_m_user;

    t_row_kind n_rk;
    t_col_kind n_ck;
    logic      col_end;
    logic      row_end;
    logic      out_free;
    logic      emit;
    logic      done;
    t_row_kind rk_start;
    t_col_kind ck_start;
    t_col_kind ck_restart;

    t_weights             wt;
    logic [12:0]          prod_ul, prod_up, prod_lf, prod_p;
    logic [13:0]          acc;
    logic [CXW-1:0]       col_x;
    logic [RXW-1:0]       row_x;
    logic [PIX_W-1:0]     pix_val;

    assign out_free = !r_m_valid || i_ready;
    assign emit     = r_s2_valid && out_free;
    assign done     = emit && col_end && row_end;
    assign o_ready  = !r_s2_valid || done;

    assign rk_start   = i_item.first_row ? ROW_TOP : ROW_UP;
    assign ck_start   = i_item.first_col ? COL_FIRST : COL_ODD;
    assign ck_restart = r_item.first_col ? COL_FIRST : COL_ODD;

    // next position in the sequence of results
    always_comb begin
        n_ck    = r_ck;
        col_end = 1'b1;
        case (r_ck)
            COL_FIRST, COL_EVEN: begin
                col_end = !r_item.last_col;
                n_ck    = COL_LAST;
            end
            COL_ODD: begin
                col_end = 1'b0;
                n_ck    = COL_EVEN;
            end
            default: begin
                col_end = 1'b1;
                n_ck    = COL_LAST;
            end
        endcase
    end

    always_comb begin
        n_rk    = r_rk;
        row_end = 1'b1;
        case (r_rk)
            ROW_TOP, ROW_DN: begin
                row_end = !r_item.last_row;
                n_rk    = ROW_BOT;
            end
            ROW_UP: begin
                row_end = 1'b0;
                n_rk    = ROW_DN;
            end
            default: begin
                row_end = 1'b1;
                n_rk    = ROW_BOT;
            end
        endcase
    end

    // value and coordinates of the current result; a neighbor with zero weight
    // drops out entirely, so a line word not yet written never reaches the sum
    always_comb begin
        wt      = blend_weights(r_rk, r_ck);
        prod_ul = (wt.ul == '0) ? '0 : {8'd0, wt.ul} * {5'd0, r_item.ul};
        prod_up = (wt.up == '0) ? '0 : {8'd0, wt.up} * {5'd0, r_item.up};
        prod_lf = (wt.lf == '0) ? '0 : {8'd0, wt.lf} * {5'd0, r_item.lf};
        prod_p  = (wt.p == '0)  ? '0 : {8'd0, wt.p}  * {5'd0, r_item.p};
        acc     = {1'b0, prod_ul} + {1'b0, prod_up} + {1'b0, prod_lf} + {1'b0, prod_p};
        pix_val = acc[11:4];

        case (r_ck)
            COL_FIRST: col_x = '0;
            COL_ODD:   col_x = CXW'({r_col, 1'b0}) - CXW'(1);
            COL_EVEN:  col_x = CXW'({r_col, 1'b0});
            default:   col_x = CXW'({r_wm1, 1'b1});
        endcase

        case (r_rk)
            ROW_TOP: row_x = '0;
            ROW_UP:  row_x = RXW'({r_row, 1'b0}) - RXW'(1);
            ROW_DN:  row_x = RXW'({r_row, 1'b0});
            default: row_x = RXW'({r_hm1, 1'b1});
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_rk       <= ROW_TOP;
            r_ck       <= COL_FIRST;
            r_m_valid  <= 1'b0;
        end else begin
            if (i_load) begin
                r_s2_valid <= 1'b1;
                r_rk       <= rk_start;
                r_ck       <= ck_start;
            end else if (done) begin
                r_s2_valid <= 1'b0;
            end else if (emit) begin
                if (col_end) begin
                    r_ck <= ck_restart;
                    r_rk <= n_rk;
                end else begin
                    r_ck <= n_ck;
                end
            end

            if (emit) begin
                r_m_valid <= 1'b1;
            end else if (i_ready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_item;
            r_col  <= i_col;
            r_wm1  <= i_wm1;
            r_row  <= i_row;
            r_hm1  <= i_hm1;
        end
        if (emit) begin
            r_m_data <= {{(TDATA_W - PIX_W - DST_COL_W - DST_ROW_W){1'b0}},
                         row_x[DST_ROW_W-1:0], col_x[DST_COL_W-1:0], pix_val};
            r_m_last <= col_end && row_end;
            r_m_user <= col_end && row_end && r_item.last_col && r_item.last_row;
        end
    end

    assign o_valid = r_m_valid;
    assign o_data  = r_m_data;
    assign o_last  = r_m_last;
    assign o_user  = r_m_user;

endmodule

[design/bilinear_upscale_2x.sv]
// An accepted pixel passes the stage 1 register, the emitter and its output register.
// Throughput: one result word per cycle while m_axis_tready holds; a pixel has 1 to 9
//   results, 4 on average, set by the single-word emit sequencer behind the line memory.
// A new pixel is accepted while the previous one is still emitting.
// Reset (i_rst_n low at a clock edge): clears positions, neighbor pixels, valids and sets
//   the size registers to 2048 x 4096; the line memory is not cleared.
module bilinear_upscale_2x #(
    parameter int MAX_SRC_WIDTH  = blu_pkg::MAX_SRC_WIDTH_DEF,
    parameter int MAX_SRC_HEIGHT = blu_pkg::MAX_SRC_HEIGHT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [blu_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [blu_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // source pixels
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [blu_pkg::PIX_W-1:0]       s_axis_tdata,   // [7:0] pixel
    // destination pixels
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [blu_pkg::TDATA_W-1:0]     m_axis_tdata,   // [7:0] out_pixel, [19:8] dst_col,
                                                            // [32:20] dst_row, [39:33] zero
    output logic                            m_axis_tlast,   // last_of_run
    output logic                            m_axis_tuser    // [0] frame_done
);
    import blu_pkg::*;

    localparam int COL_W = $clog2(MAX_SRC_WIDTH);
    localparam int ROW_W = $clog2(MAX_SRC_HEIGHT);
    localparam int W_RST = (CFG_WID_RST > MAX_SRC_WIDTH)  ? MAX_SRC_WIDTH  : CFG_WID_RST;
    localparam int H_RST = (CFG_HGT_RST > MAX_SRC_HEIGHT) ? MAX_SRC_HEIGHT : CFG_HGT_RST;

    // Size registers hold the clamped size minus one, so a stored value is always usable.
    logic [COL_W-1:0] r_wm1, n_wm1;
    logic [ROW_W-1:0] r_hm1, n_hm1;
    logic [CFG_WID_W-1:0] cfg_wid;
    logic [CFG_HGT_W-1:0] cfg_hgt;

    // position of the next source pixel and its neighbors
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [PIX_W-1:0] r_left;
    logic [PIX_W-1:0] r_ul;

    // stage 1: waiting for the line memory word
    logic             r_s1_valid;
    logic [PIX_W-1:0] r_s1_p;
    logic [PIX_W-1:0] r_s1_lf;
    logic [COL_W-1:0] r_s1_col;
    logic [COL_W-1:0] r_s1_wm1;
    logic [ROW_W-1:0] r_s1_row;
    logic [ROW_W-1:0] r_s1_hm1;

    logic [COL_W-1:0] cur_col;
    logic [ROW_W-1:0] cur_row;
    logic             accept;
    logic             s1_adv;
    logic             emit_ready;
    logic [PIX_W-1:0] ram_rdata;
    t_item            item;

    assign cfg_wid = i_cfg_data[CFG_WID_W-1:0];
    assign cfg_hgt = i_cfg_data[CFG_HGT_W-1:0];

    // clamp: zero acts as one, above the maximum acts as the maximum
    always_comb begin
        if (cfg_wid == '0) begin
            n_wm1 = '0;
        end else if (32'(cfg_wid) > 32'(MAX_SRC_WIDTH)) begin
            n_wm1 = COL_W'(MAX_SRC_WIDTH - 1);
        end else begin
            n_wm1 = COL_W'(cfg_wid - 1'b1);
        end

        if (cfg_hgt == '0) begin
            n_hm1 = '0;
        end else if (32'(cfg_hgt) > 32'(MAX_SRC_HEIGHT)) begin
            n_hm1 = ROW_W'(MAX_SRC_HEIGHT - 1);
        end else begin
            n_hm1 = ROW_W'(cfg_hgt - 1'b1);
        end
    end

    // A position left beyond a shrunk size snaps to the last column or row.
    assign cur_col = (r_col > r_wm1) ? r_wm1 : r_col;
    assign cur_row = (r_row > r_hm1) ? r_hm1 : r_row;

    always_comb begin
        if (cur_col == r_wm1) begin
            n_col = '0;
            n_row = (cur_row == r_hm1) ? '0 : cur_row + 1'b1;
        end else begin
            n_col = cur_col + 1'b1;
            n_row = cur_row;
        end
    end

    // Stage 1 holds one pixel until the emitter takes it; the memory word holds with it.
    assign s1_adv        = r_s1_valid && emit_ready;
    assign s_axis_tready = !r_s1_valid || s1_adv;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wm1      <= COL_W'(W_RST - 1);
            r_hm1      <= ROW_W'(H_RST - 1);
            r_col      <= '0;
            r_row      <= '0;
            r_left     <= '0;
            r_ul       <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_idx))
                    CFG_SRC_WIDTH:  r_wm1 <= n_wm1;
                    CFG_SRC_HEIGHT: r_hm1 <= n_hm1;
                    default: ;
                endcase
            end
            if (accept) begin
                r_col  <= n_col;
                r_row  <= n_row;
                r_left <= s_axis_tdata;
            end
            // the word above this pixel becomes the upper-left of the next one
            if (s1_adv) begin
                r_ul <= ram_rdata;
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_p   <= s_axis_tdata;
            r_s1_lf  <= r_left;
            r_s1_col <= cur_col;
            r_s1_wm1 <= r_wm1;
            r_s1_row <= cur_row;
            r_s1_hm1 <= r_hm1;
        end
    end

    // Line memory: read the pixel above and overwrite it with the new one in the same cycle.
    blu_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_SRC_WIDTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (cur_col),
        .i_wdata (s_axis_tdata),
        .i_re    (accept),
        .i_raddr (cur_col),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        item.ul        = r_ul;
        item.up        = ram_rdata;
        item.lf        = r_s1_lf;
        item.p         = r_s1_p;
        item.first_col = (r_s1_col == '0);
        item.last_col  = (r_s1_col == r_s1_wm1);
        item.first_row = (r_s1_row == '0);
        item.last_row  = (r_s1_row == r_s1_hm1);
    end

    blu_emit #(
        .COL_W (COL_W),
        .ROW_W (ROW_W)
    ) u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (s1_adv),
        .i_item  (item),
        .i_col   (r_s1_col),
        .i_wm1   (r_s1_wm1),
        .i_row   (r_s1_row),
        .i_hm1   (r_s1_hm1),
        .o_ready (emit_ready),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata),
        .o_last  (m_axis_tlast),
        .o_user  (m_axis_tuser)
    );

endmodule

[design/blu_checker.sv]
module blu_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [blu_pkg::TDATA_W-1:0] m_axis_tdata,
    input logic                        m_axis_tlast,
    input logic                        m_axis_tuser
);
    import blu_pkg::*;

    // the frame ends only on the last word of a pixel
    a_frame_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("frame_done without last_of_run");

    // padding bits above the row stay zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[TDATA_W-1:PIX_W+DST_COL_W+DST_ROW_W] == '0)
        else $error("nonzero tdata padding");

    // nothing is offered right after reset
    a_quiet_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // a stalled word is held
    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output word changed");

endmodule

bind bilinear_upscale_2x blu_checker u_blu_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);
